// ===== hw/rtl/ffux_pkg.sv =====
// Package for the flag frame unescape and XOR check block: codes, constants and types.
`default_nettype none
package ffux_pkg;

	// Link byte codes
	localparam logic [7:0] FLAG_BYTE     = 8'h7e;
	localparam logic [7:0] ESC_BYTE      = 8'h7d;
	localparam logic [7:0] ESC_FLAG_CODE = 8'h02;
	localparam logic [7:0] ESC_ESC_CODE  = 8'h01;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 2;

	// Final status of a frame
	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_MISMATCH   = 2'd1,
		ST_SHORT      = 2'd2,
		ST_BAD_ESCAPE = 2'd3
	} status_t;

	// One result item from the frame logic
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              last;
		status_t           status;
	} res_t;

	// Receiver state between items
	typedef struct packed {
		logic               in_frame;
		logic               esc_pend;
		logic [BYTE_W-1:0]  held_byte;
		logic               held_valid;
		logic [BYTE_W-1:0]  run_xor;
		logic [COUNT_W-1:0] count;
		logic               esc_err;
	} frame_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/flag_frame_unescape_xor_check.sv =====
// Top level: input register, frame logic and output register with handshakes.
// A line byte is taken into the input register; its result item is then registered in the output register.
// Throughput: one line byte per cycle while the output is not stalled.
// Backpressure on the output stalls the input register only when it is full.
// Reset (arst_n low, asynchronous) empties both registers and returns to hunting.
`default_nettype none
module flag_frame_unescape_xor_check (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ffux_pkg::BYTE_W-1:0]   line_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ffux_pkg::BYTE_W-1:0]        payload_byte,
	output logic                               frame_end,
	output logic [ffux_pkg::STATUS_W-1:0]      frame_status
);
	import ffux_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	logic              fire;
	res_t              res;

	// The output register can take a new item when empty or being drained
	assign out_free  = !out_valid || out_ready;
	assign fire      = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			byte_s1  <= line_byte;
		end
	end

	ffux_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.line_byte (byte_s1),
		.res       (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			payload_byte <= '0;
			frame_end    <= 1'b0;
			frame_status <= '0;
		end else if (out_free) begin
			out_valid    <= fire && res.valid;
			payload_byte <= res.data;
			frame_end    <= res.last;
			frame_status <= res.status;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ffux_core.sv =====
// Frame hunt, escape removal, hold-back byte and running XOR check.
`default_nettype none
module ffux_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire logic [ffux_pkg::BYTE_W-1:0]   line_byte,
	output ffux_pkg::res_t                     res
);
	import ffux_pkg::*;

	frame_state_t      cur_q;
	frame_state_t      nxt;
	logic              pending;
	logic              data_ok;
	logic [BYTE_W-1:0] data;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_TWO = COUNT_W'(2);

	assign pending = cur_q.held_valid | cur_q.esc_pend | cur_q.esc_err;

	// Next state and result for the item in the input register
	always_comb begin
		nxt     = cur_q;
		res     = '0;
		data_ok = 1'b0;
		data    = '0;
		if (fire) begin
			if (line_byte == FLAG_BYTE) begin
				nxt = '0;
				if (cur_q.in_frame && pending) begin
					// close the frame, held byte is the check byte
					res.valid = 1'b1;
					res.last  = 1'b1;
					res.data  = cur_q.held_valid ? cur_q.held_byte : '0;
					if (cur_q.esc_err || cur_q.esc_pend)
						res.status = ST_BAD_ESCAPE;
					else if (cur_q.count < COUNT_TWO)
						res.status = ST_SHORT;
					else if (cur_q.held_byte != cur_q.run_xor)
						res.status = ST_MISMATCH;
					else
						res.status = ST_OK;
				end else begin
					nxt.in_frame = 1'b1;
				end
			end else if (cur_q.in_frame) begin
				// escape removal
				if (cur_q.esc_pend) begin
					nxt.esc_pend = 1'b0;
					if (line_byte == ESC_FLAG_CODE) begin
						data    = FLAG_BYTE;
						data_ok = 1'b1;
					end else if (line_byte == ESC_ESC_CODE) begin
						data    = ESC_BYTE;
						data_ok = 1'b1;
					end else begin
						nxt.esc_err = 1'b1;
					end
				end else if (line_byte == ESC_BYTE) begin
					nxt.esc_pend = 1'b1;
				end else begin
					data    = line_byte;
					data_ok = 1'b1;
				end
				// release the held byte, hold the new one
				if (data_ok) begin
					if (cur_q.held_valid) begin
						res.valid   = 1'b1;
						res.data    = cur_q.held_byte;
						res.last    = 1'b0;
						res.status  = ST_OK;
						nxt.run_xor = cur_q.run_xor ^ cur_q.held_byte;
					end
					nxt.held_byte  = data;
					nxt.held_valid = 1'b1;
					if (cur_q.count != COUNT_MAX)
						nxt.count = cur_q.count + COUNT_W'(1);
				end
			end
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else begin
			cur_q <= nxt;
		end
	end

	// Checks
	a_last_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.last) |-> cur_q.in_frame)
		else $error("frame closed while hunting");
	a_close_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.last) |=> (!cur_q.in_frame && !cur_q.held_valid))
		else $error("state not cleared after close");
	a_held_counted: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q.held_valid |-> (cur_q.count != '0))
		else $error("held byte without count");
	a_mid_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.last) |-> (res.status == ST_OK))
		else $error("status on a non-final item");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the flag frame unescape and XOR check block: stimulus, predictor and checker.
`timescale 1ns / 100ps
module tb_top;
	import ffux_pkg::*;

	localparam int unsigned RANDOM_ITEMS   = 1900;
	localparam int unsigned CALM_TAIL      = 300;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 8;

	// How a stimulus row is checked
	typedef enum logic [1:0] {
		ROW_PRED,  // expectation comes from the predictor
		ROW_NONE,  // typed in: no output byte
		ROW_RES    // typed in: one output byte
	} row_kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		status_t           status;
	} frame_out_t;

	typedef struct packed {
		logic [BYTE_W-1:0] line;
		row_kind_t         kind;
		frame_out_t        exp;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [BYTE_W-1:0]   line_byte = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [BYTE_W-1:0]   payload_byte;
	logic                frame_end;
	logic [STATUS_W-1:0] frame_status;

	stim_row_t  stim_q[$];
	frame_out_t expected_bytes_q[$];
	int unsigned err_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned out_stall_left = 0;
	bit          idle_on = 1'b1;

	// Predictor state
	logic               rx_in_frame;
	logic               rx_esc_pend;
	logic [BYTE_W-1:0]  rx_held_byte;
	logic               rx_held_valid;
	logic [BYTE_W-1:0]  rx_run_xor;
	logic [COUNT_W-1:0] rx_count;
	logic               rx_esc_err;

	flag_frame_unescape_xor_check dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.line_byte    (line_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.frame_end    (frame_end),
		.frame_status (frame_status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic clear_rx_frame();
		rx_esc_pend   = 1'b0;
		rx_held_byte  = '0;
		rx_held_valid = 1'b0;
		rx_run_xor    = '0;
		rx_count      = '0;
		rx_esc_err    = 1'b0;
	endtask

	// Receiver predictor: one line byte in, at most one frame byte out
	task automatic predict_rx(input logic [BYTE_W-1:0] b, output bit produced,
			output frame_out_t r);
		logic [BYTE_W-1:0] data;
		bit                take;
		produced = 1'b0;
		take     = 1'b0;
		data     = '0;
		r        = '{data: '0, last: 1'b0, status: ST_OK};
		if (b == FLAG_BYTE) begin
			if (rx_in_frame && (rx_held_valid || rx_esc_pend || rx_esc_err)) begin
				produced = 1'b1;
				r.data   = rx_held_valid ? rx_held_byte : '0;
				r.last   = 1'b1;
				// bad escape beats too short, which beats mismatch
				if (rx_esc_err || rx_esc_pend)
					r.status = ST_BAD_ESCAPE;
				else if (rx_count < 2)
					r.status = ST_SHORT;
				else if (rx_held_byte != rx_run_xor)
					r.status = ST_MISMATCH;
				else
					r.status = ST_OK;
				rx_in_frame = 1'b0;
			end else begin
				rx_in_frame = 1'b1;
			end
			clear_rx_frame();
		end else if (rx_in_frame) begin
			if (rx_esc_pend) begin
				rx_esc_pend = 1'b0;
				if (b == ESC_FLAG_CODE) begin
					data = FLAG_BYTE;
					take = 1'b1;
				end else if (b == ESC_ESC_CODE) begin
					data = ESC_BYTE;
					take = 1'b1;
				end else begin
					rx_esc_err = 1'b1;
				end
			end else if (b == ESC_BYTE) begin
				rx_esc_pend = 1'b1;
			end else begin
				data = b;
				take = 1'b1;
			end
			// new byte releases the held one into the XOR
			if (take) begin
				if (rx_held_valid) begin
					produced   = 1'b1;
					r.data     = rx_held_byte;
					rx_run_xor = rx_run_xor ^ rx_held_byte;
				end
				rx_held_byte  = data;
				rx_held_valid = 1'b1;
				if (rx_count != 2'd3)
					rx_count = rx_count + 2'd1;
			end
		end
	endtask

	task automatic add_row(input logic [BYTE_W-1:0] b, input row_kind_t k,
			input logic [BYTE_W-1:0] d = '0, input logic l = 1'b0, input status_t s = ST_OK);
		stim_q.push_back('{line: b, kind: k, exp: '{data: d, last: l, status: s}});
	endtask

	// Directed table: hunting, reopen, each status, escapes, flag after escape
	task automatic build_directed();
		add_row(8'h00,     ROW_NONE);
		add_row(FLAG_BYTE, ROW_NONE);
		add_row(FLAG_BYTE, ROW_NONE);
		add_row(8'h41,     ROW_NONE);
		add_row(FLAG_BYTE, ROW_RES, 8'h41, 1'b1, ST_SHORT);
		add_row(FLAG_BYTE, ROW_NONE);
		add_row(8'h00,     ROW_NONE);
		add_row(8'h00,     ROW_RES, 8'h00, 1'b0, ST_OK);
		add_row(FLAG_BYTE, ROW_RES, 8'h00, 1'b1, ST_OK);
		add_row(FLAG_BYTE, ROW_NONE);
		add_row(8'hff,     ROW_NONE);
		add_row(ESC_BYTE,  ROW_NONE);
		add_row(ESC_FLAG_CODE, ROW_PRED);
		add_row(ESC_BYTE,  ROW_NONE);
		add_row(ESC_ESC_CODE,  ROW_PRED);
		add_row(FLAG_BYTE, ROW_RES, ESC_BYTE, 1'b1, ST_MISMATCH);
		add_row(FLAG_BYTE, ROW_NONE);
		add_row(ESC_BYTE,  ROW_NONE);
		add_row(8'h33,     ROW_NONE);
		add_row(FLAG_BYTE, ROW_RES, 8'h00, 1'b1, ST_BAD_ESCAPE);
		add_row(FLAG_BYTE, ROW_NONE);
		add_row(8'haa,     ROW_NONE);
		add_row(ESC_BYTE,  ROW_NONE);
		add_row(FLAG_BYTE, ROW_RES, 8'haa, 1'b1, ST_BAD_ESCAPE);
		add_row(8'h80,     ROW_NONE);
	endtask

	function automatic logic [BYTE_W-1:0] rand_data();
		logic [BYTE_W-1:0] specials[4];
		specials = '{FLAG_BYTE, ESC_BYTE, ESC_FLAG_CODE, ESC_ESC_CODE};
		if ($urandom_range(0, 99) < 15)
			return specials[$urandom_range(0, 3)];
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// Random part: mostly well-formed escaped frames, some noise and damage
	task automatic build_random();
		int unsigned       target;
		int unsigned       n;
		int unsigned       pick;
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] d;
		target = stim_q.size() + RANDOM_ITEMS;
		while (stim_q.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 4))
					add_row(BYTE_W'($urandom_range(0, 255)), ROW_PRED);
			end else begin
				add_row(FLAG_BYTE, ROW_PRED);
				if ($urandom_range(0, 9) == 0)
					add_row(FLAG_BYTE, ROW_PRED);
				n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10)
					: $urandom_range(0, 40);
				acc = '0;
				for (int unsigned i = 0; i < n; i++) begin
					if (i == n - 1 && n > 1 && $urandom_range(0, 9) < 7)
						d = acc;
					else
						d = rand_data();
					acc = acc ^ d;
					if ($urandom_range(0, 99) < 2) begin
						add_row(ESC_BYTE, ROW_PRED);
						add_row(BYTE_W'($urandom_range(0, 255)), ROW_PRED);
					end
					if (d == FLAG_BYTE) begin
						add_row(ESC_BYTE, ROW_PRED);
						add_row(ESC_FLAG_CODE, ROW_PRED);
					end else if (d == ESC_BYTE) begin
						add_row(ESC_BYTE, ROW_PRED);
						add_row(ESC_ESC_CODE, ROW_PRED);
					end else begin
						add_row(d, ROW_PRED);
					end
				end
				// close: normal flag, flag after a lone escape, or left open
				pick = $urandom_range(0, 99);
				if (pick < 90) begin
					add_row(FLAG_BYTE, ROW_PRED);
				end else if (pick < 95) begin
					add_row(ESC_BYTE, ROW_PRED);
					add_row(FLAG_BYTE, ROW_PRED);
				end
			end
		end
	endtask

	// Apply an accepted item to the predictor and queue what it should produce
	task automatic accept_item(input stim_row_t row);
		bit         produced;
		frame_out_t r;
		predict_rx(row.line, produced, r);
		case (row.kind)
			ROW_RES: begin
				expected_bytes_q.push_back(row.exp);
			end
			ROW_PRED: begin
				if (produced)
					expected_bytes_q.push_back(r);
			end
			default: begin
			end
		endcase
	endtask

	// Stimulus driver
	initial begin
		stim_row_t   row;
		int unsigned total;
		clear_rx_frame();
		rx_in_frame = 1'b0;
		build_directed();
		build_random();
		total = stim_q.size();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int unsigned idx = 0; idx < total; idx++) begin
			row = stim_q[idx];
			idle_on = (idx + CALM_TAIL < total) && ((idx / 250) % 3 != 2);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			in_valid  <= 1'b1;
			line_byte <= row.line;
			do
				@(posedge clk);
			while (!in_ready);
			accept_item(row);
		end
		in_valid <= 1'b0;
		while (expected_bytes_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] exp_v,
			input logic [BYTE_W-1:0] act_v);
		err_count++;
		$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
	endtask

	// Output checker and receiver stalls
	always @(posedge clk) begin
		frame_out_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_bytes_q.size() == 0) begin
					err_count++;
					$display("%0t: unexpected item: expected none, actual %0h end %0b st %0d",
						$time, payload_byte, frame_end, frame_status);
				end else begin
					e = expected_bytes_q.pop_front();
					if (payload_byte !== e.data)
						report_mismatch("payload_byte", e.data, payload_byte);
					if (frame_end !== e.last)
						report_mismatch("frame_end", BYTE_W'(e.last), BYTE_W'(frame_end));
					if (frame_status !== e.status)
						report_mismatch("frame_status", BYTE_W'(e.status),
							BYTE_W'(frame_status));
				end
			end
			if (out_stall_left != 0) begin
				out_ready <= 1'b0;
				out_stall_left = out_stall_left - 1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				out_stall_left = $urandom_range(1, 9) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
hw/rtl/ffux_pkg.sv
hw/rtl/ffux_core.sv
hw/rtl/flag_frame_unescape_xor_check.sv
tb/tb_top.sv
